// ===== rtl/sosp_pkg.sv =====
// Package for the set-of-stacks block: sizes, command and status codes,
// and the control struct handed from the top level to each storage cell.
// No dependencies.
package sosp_pkg;

	// Store geometry
	localparam int TOTAL_DEPTH  = 64;
	localparam int SUB_CAPACITY = 3;

	// Field widths fixed by the interface
	localparam int OP_W     = 2;
	localparam int WORD_W   = 32;
	localparam int SEL_W    = 6;
	localparam int STATUS_W = 2;
	localparam int SCNT_W   = 5;
	localparam int ECNT_W   = 7;

	// Internal widths
	localparam int CNT_W  = $clog2(TOTAL_DEPTH + 1);
	localparam int IDX_W  = $clog2(TOTAL_DEPTH);
	localparam int FILL_W = $clog2(SUB_CAPACITY + 1);
	localparam int PROD_W = CNT_W + FILL_W;

	// Command codes
	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_AT = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	// Per-cell control: load the pushed word, or take the upper neighbour's word
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== rtl/sosp_cell.sv =====
// One storage cell of the word row: holds a single word, loads a pushed
// word or takes its upper neighbour's word when a removal passes it.
// Depends on sosp_pkg.
module sosp_cell
	import sosp_pkg::*;
(
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [WORD_W-1:0] push_word,
	input  logic [WORD_W-1:0] upper_word,
	output logic [WORD_W-1:0] word
);

	logic [WORD_W-1:0] word_q;

	// Word register: no reset, contents above the fill level are never read
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			word_q <= push_word;
		end else if (ctrl.shift) begin
			word_q <= upper_word;
		end
	end

	assign word = word_q;

endmodule

// ===== rtl/set_of_stacks_with_pop_at.sv =====
// Set of stacks with rollover: a packed row of word cells split into
// sub-stacks of fixed capacity. Depends on sosp_pkg and sosp_cell.
//
// One request is taken per clock cycle and its result appears in the output
// register on the following cycle; a new request is taken while that result
// waits, as long as the output side takes it in the same cycle. A pop or pop_at
// moves every word above the removed place down by one through the cell row in
// the cycle it is taken, so the throughput is set by that cell row and is one
// request per cycle whatever the command, unless the output side stalls. The store
// contents need no clearing after reset; only the counts and out_valid are reset.
module set_of_stacks_with_pop_at
	import sosp_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [OP_W-1:0]            operation,
	input  logic signed [WORD_W-1:0]   push_value,
	input  logic [SEL_W-1:0]           sub_stack_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic signed [WORD_W-1:0]   popped_value,
	output logic [SCNT_W-1:0]          stack_count,
	output logic [ECNT_W-1:0]          element_count
);

	// Counts
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  subs_q;
	logic [FILL_W-1:0] fill_q;

	// Output register
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [WORD_W-1:0]    popped_q;
	logic [SCNT_W-1:0]    scount_q;
	logic [ECNT_W-1:0]    ecount_q;

	logic                 accept;
	logic                 is_empty;
	logic                 is_full;
	logic                 in_range;
	logic                 push_ok;
	logic                 take;
	logic [STATUS_W-1:0]  status_d;
	logic [PROD_W-1:0]    end_raw;
	logic [PROD_W-1:0]    end_clip;
	logic [PROD_W-1:0]    total_ext;
	logic [PROD_W-1:0]    pos_ext;
	logic [IDX_W-1:0]     pos;
	logic [CNT_W-1:0]     total_d;
	logic [CNT_W-1:0]     subs_d;
	logic [FILL_W-1:0]    fill_d;
	logic [WORD_W-1:0]    popped_d;

	logic [WORD_W-1:0]    words [TOTAL_DEPTH];
	cell_ctrl_t           ctrls [TOTAL_DEPTH];

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// Command decode and checks
	assign is_empty  = (total_q == '0);
	assign is_full   = (total_q >= CNT_W'(TOTAL_DEPTH));
	assign in_range  = (CNT_W'(sub_stack_index) < subs_q);
	assign push_ok   = accept && (operation == OP_PUSH) && !is_full;
	assign take      = accept && !is_empty &&
		((operation == OP_POP) || ((operation == OP_POP_AT) && in_range));

	always_comb begin
		case (operation)
			OP_PUSH:   status_d = is_full ? ST_FULL : ST_OK;
			OP_POP:    status_d = is_empty ? ST_EMPTY : ST_OK;
			OP_POP_AT: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (!in_range) begin
					status_d = ST_RANGE;
				end else begin
					status_d = ST_OK;
				end
			end
			default:   status_d = ST_OK;
		endcase
	end

	// Place of the removed word: top of the chosen sub-stack, clipped to the global top
	assign total_ext = PROD_W'(total_q);
	assign end_raw   = (PROD_W'(sub_stack_index) + PROD_W'(1)) * PROD_W'(SUB_CAPACITY);
	assign end_clip  = ((operation == OP_POP) || (end_raw > total_ext)) ? total_ext : end_raw;
	assign pos_ext   = end_clip - PROD_W'(1);
	assign pos       = pos_ext[IDX_W-1:0];

	assign popped_d  = take ? words[pos] : '0;

	// Count update: total, sub-stack count and fill of the top sub-stack
	always_comb begin
		total_d = total_q;
		subs_d  = subs_q;
		fill_d  = fill_q;
		if (push_ok) begin
			total_d = total_q + CNT_W'(1);
			if ((fill_q == '0) || (fill_q == FILL_W'(SUB_CAPACITY))) begin
				subs_d = subs_q + CNT_W'(1);
				fill_d = FILL_W'(1);
			end else begin
				fill_d = fill_q + FILL_W'(1);
			end
		end else if (take) begin
			total_d = total_q - CNT_W'(1);
			if (fill_q == FILL_W'(1)) begin
				subs_d = subs_q - CNT_W'(1);
				fill_d = (subs_q > CNT_W'(1)) ? FILL_W'(SUB_CAPACITY) : '0;
			end else begin
				fill_d = fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			subs_q  <= '0;
			fill_q  <= '0;
		end else begin
			total_q <= total_d;
			subs_q  <= subs_d;
			fill_q  <= fill_d;
		end
	end

	// Row of storage cells, each fed by its upper neighbour
	for (genvar i = 0; i < TOTAL_DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] upper;

		if (i == TOTAL_DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid
			assign upper = words[i+1];
		end

		assign ctrls[i].load  = push_ok && (total_q == CNT_W'(i));
		assign ctrls[i].shift = take && (IDX_W'(i) >= pos);

		sosp_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrls[i]),
			.push_word  (push_value),
			.upper_word (upper),
			.word       (words[i])
		);
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			popped_q <= popped_d;
			scount_q <= subs_d[SCNT_W-1:0];
			ecount_q <= total_d[ECNT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign popped_value  = popped_q;
	assign stack_count   = scount_q;
	assign element_count = ecount_q;

endmodule

// ===== dv/tb_set_of_stacks_with_pop_at.sv =====
`timescale 1ns / 100ps
// Self-checking bench for set_of_stacks_with_pop_at: directed table, then random
// requests under four handshake phases, each result checked against a typed value or a local model.
// Depends on sosp_pkg and the set_of_stacks_with_pop_at RTL.
module tb_set_of_stacks_with_pop_at;
	import sosp_pkg::*;

	// Operation code the block ignores
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int N_DIRECTED = 20;
	localparam int N_PER_PHASE = 425;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   popped;
		logic [SCNT_W-1:0]   subs;
		logic [ECNT_W-1:0]   elems;
	} stack_result_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [WORD_W-1:0] word;
		logic [SEL_W-1:0]  sel;
		logic              literal;
		stack_result_t     result;
	} directed_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [OP_W-1:0]          operation = OP_PUSH;
	logic signed [WORD_W-1:0] push_value = '0;
	logic [SEL_W-1:0]         sub_stack_index = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [STATUS_W-1:0]      status;
	logic signed [WORD_W-1:0] popped_value;
	logic [SCNT_W-1:0]        stack_count;
	logic [ECNT_W-1:0]        element_count;

	// Local copy of the store
	logic [WORD_W-1:0] model_words [TOTAL_DEPTH];
	int                model_total = 0;

	stack_result_t pending_results [$];
	int fail_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int n_requests = 0, n_full = 0, n_empty = 0, n_range = 0, peak_fill = 0;

	// Directed rows; a typed result is used where it is obvious, else the model decides
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{OP_POP,    32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY, 32'h0, 5'd0, 7'd0}},
		'{OP_POP_AT, 32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY, 32'h0, 5'd0, 7'd0}},
		// empty takes priority over a bad index
		'{OP_POP_AT, 32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_EMPTY, 32'h0, 5'd0, 7'd0}},
		'{OP_SPARE,  32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_OK,    32'h0, 5'd0, 7'd0}},
		'{OP_PUSH,   32'h7FFF_FFFF, 6'd0,  1'b1, '{ST_OK,    32'h0, 5'd1, 7'd1}},
		'{OP_PUSH,   32'h8000_0000, 6'd63, 1'b1, '{ST_OK,    32'h0, 5'd1, 7'd2}},
		'{OP_PUSH,   32'h0000_0000, 6'd0,  1'b1, '{ST_OK,    32'h0, 5'd1, 7'd3}},
		'{OP_PUSH,   32'hFFFF_FFFF, 6'd0,  1'b1, '{ST_OK,    32'h0, 5'd2, 7'd4}},
		'{OP_PUSH,   32'h5A5A_5A5A, 6'd0,  1'b1, '{ST_OK,    32'h0, 5'd2, 7'd5}},
		// index one past the last sub-stack, then the top index
		'{OP_POP_AT, 32'h0000_0000, 6'd2,  1'b1, '{ST_RANGE, 32'h0, 5'd2, 7'd5}},
		'{OP_POP_AT, 32'h0000_0000, 6'd63, 1'b1, '{ST_RANGE, 32'h0, 5'd2, 7'd5}},
		'{OP_SPARE,  32'h0000_0000, 6'd0,  1'b1, '{ST_OK,    32'h0, 5'd2, 7'd5}},
		// pop from a full lower sub-stack rolls the next bottom down
		'{OP_POP_AT, 32'h0000_0000, 6'd0,  1'b0, '0},
		// last sub-stack behaves as a plain pop
		'{OP_POP_AT, 32'h0000_0000, 6'd1,  1'b0, '0},
		'{OP_POP,    32'h0000_0000, 6'd0,  1'b0, '0},
		'{OP_PUSH,   32'h1234_5678, 6'd0,  1'b0, '0},
		'{OP_POP_AT, 32'h0000_0000, 6'd0,  1'b0, '0},
		'{OP_POP,    32'h0000_0000, 6'd0,  1'b0, '0},
		'{OP_POP,    32'h0000_0000, 6'd0,  1'b0, '0},
		'{OP_POP,    32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY, 32'h0, 5'd0, 7'd0}}
	};

	set_of_stacks_with_pop_at dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.push_value(push_value),
		.sub_stack_index(sub_stack_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.popped_value(popped_value),
		.stack_count(stack_count),
		.element_count(element_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("tb_set_of_stacks_with_pop_at failed");
		$finish;
	end

	function automatic int sub_stacks_used();
		return (model_total + SUB_CAPACITY - 1) / SUB_CAPACITY;
	endfunction

	// Remove one word and close the gap above it
	function automatic logic [WORD_W-1:0] take_word(input int pos);
		logic [WORD_W-1:0] word;
		word = model_words[pos];
		for (int k = pos; k + 1 < model_total; k++)
			model_words[k] = model_words[k + 1];
		model_total--;
		return word;
	endfunction

	// Apply one request to the local store and return its result
	function automatic stack_result_t predict_stack_op(input logic [OP_W-1:0] op,
			input logic [WORD_W-1:0] word, input logic [SEL_W-1:0] sel);
		stack_result_t r;
		int top_pos;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_PUSH: begin
				if (model_total >= TOTAL_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					model_words[model_total] = word;
					model_total++;
				end
			end
			OP_POP: begin
				if (model_total == 0)
					r.status = ST_EMPTY;
				else
					r.popped = take_word(model_total - 1);
			end
			OP_POP_AT: begin
				if (model_total == 0) begin
					r.status = ST_EMPTY;
				end else if (int'(sel) >= sub_stacks_used()) begin
					r.status = ST_RANGE;
				end else begin
					top_pos = (int'(sel) + 1) * SUB_CAPACITY;
					if (top_pos > model_total)
						top_pos = model_total;
					r.popped = take_word(top_pos - 1);
				end
			end
			default: ;
		endcase
		r.subs = SCNT_W'(sub_stacks_used());
		r.elems = ECNT_W'(model_total);
		return r;
	endfunction

	// Offer one request, wait for acceptance, queue its expected result
	task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
			input logic [SEL_W-1:0] sel, input logic literal, input stack_result_t typed);
		stack_result_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		push_value <= word;
		sub_stack_index <= sel;
		do @(posedge clk); while (!in_ready);
		r = predict_stack_op(op, word, sel);
		n_requests++;
		if (r.status == ST_FULL)
			n_full++;
		if (r.status == ST_EMPTY)
			n_empty++;
		if (r.status == ST_RANGE)
			n_range++;
		if (model_total > peak_fill)
			peak_fill = model_total;
		pending_results.insert(pending_results.size(), literal ? typed : r);
	endtask

	// Hold off the sender until every result is back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Result checker
	always @(posedge clk) begin : result_check
		stack_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: status %0d", status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (popped_value !== $signed(want.popped)) begin
					$error("popped_value: expected %0d, got %0d",
						$signed(want.popped), popped_value);
					fail_count++;
				end
				if (stack_count !== want.subs) begin
					$error("stack_count: expected %0d, got %0d", want.subs, stack_count);
					fail_count++;
				end
				if (element_count !== want.elems) begin
					$error("element_count: expected %0d, got %0d",
						want.elems, element_count);
					fail_count++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		int left;
		int seg_left;
		int push_pct;
		int pick;
		int subs;
		logic [OP_W-1:0] op;
		logic [WORD_W-1:0] word;
		logic [SEL_W-1:0] sel;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].word, directed_rows[i].sel,
				directed_rows[i].literal, directed_rows[i].result);
		wait_for_results();

		// Phases: no idling, sender gaps, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = (phase == 1) ? 46 : (phase == 3) ? 19 : 0;
			receiver_stall_pct = (phase == 2) ? 46 : (phase == 3) ? 19 : 0;
			left = N_PER_PHASE;
			seg_left = 0;
			push_pct = 48;
			while (left > 0) begin
				// Alternate filling, draining and balanced stretches to reach full and empty
				if (seg_left == 0) begin
					seg_left = $urandom_range(160, 60);
					case ($urandom_range(2))
						0: push_pct = 83;
						1: push_pct = 15;
						default: push_pct = 48;
					endcase
				end
				seg_left--;
				if ((phase == 1 && left == 200) || $urandom_range(99) == 0)
					wait_for_results();

				pick = $urandom_range(99);
				if (pick < 2)
					op = OP_SPARE;
				else if (pick < 2 + push_pct)
					op = OP_PUSH;
				else if ($urandom_range(9) < 4)
					op = OP_POP;
				else
					op = OP_POP_AT;

				case ($urandom_range(9))
					0: word = 32'h7FFF_FFFF;
					1: word = 32'h8000_0000;
					2: word = '0;
					3: word = '1;
					default: word = $urandom;
				endcase

				// Mostly a live sub-stack, often the last, sometimes any index
				subs = sub_stacks_used();
				if (subs > 0 && $urandom_range(9) < 8) begin
					if ($urandom_range(3) == 0)
						sel = SEL_W'(subs - 1);
					else
						sel = SEL_W'($urandom_range(subs - 1, 0));
				end else begin
					sel = SEL_W'($urandom_range(63, 0));
				end

				send_request(op, word, sel, 1'b0, '0);
				if (op != OP_SPARE)
					left--;
			end
			wait_for_results();
		end

		repeat (8) @(posedge clk);
		$display("Ran %0d requests over four handshake phases; refusals: %0d full, %0d empty,",
			n_requests, n_full, n_empty);
		$display("  %0d index out of range; peak fill %0d of %0d words", n_range, peak_fill,
			TOTAL_DEPTH);
		if (fail_count == 0)
			$display("tb_set_of_stacks_with_pop_at passed");
		else
			$display("tb_set_of_stacks_with_pop_at failed");
		$finish;
	end

endmodule
